// ----- hw/rtl/vip_pkg.sv -----
package vip_pkg;

    localparam int VERTEX_W = 12;
    localparam int JOINT_W  = 8;
    localparam int WEIGHT_W = 17;
    localparam int STATUS_W = 2;

    localparam int DEF_MAX_VERTICES     = 4096;
    localparam int DEF_SLOTS_PER_VERTEX = 4;
    localparam int MAX_JOINTS           = 256;

    // slots shown on a read result
    localparam int SHOWN_SLOTS = 4;

    localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);
    localparam int FRAC_W = 16;

    // share = (w * 2^16 + total / 2) / total, quotient never above 2^16
    localparam int NUM_W  = WEIGHT_W + FRAC_W;
    localparam int QUOT_W = WEIGHT_W;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_STORED  = 2'd0,
        STATUS_DROPPED = 2'd1,
        STATUS_READ    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        STATE_CLEAR,
        STATE_IDLE,
        STATE_FETCH,
        STATE_EVAL,
        STATE_DIVIDE
    } t_state;

    typedef struct packed {
        t_op                 operation;
        logic [VERTEX_W-1:0] vertex_index;
        logic [JOINT_W-1:0]  joint_index;
        logic [WEIGHT_W-1:0] weight;
    } t_request;

    typedef struct packed {
        t_status             status;
        logic [JOINT_W-1:0]  joint_a;
        logic [JOINT_W-1:0]  joint_b;
        logic [JOINT_W-1:0]  joint_c;
        logic [JOINT_W-1:0]  joint_d;
        logic [WEIGHT_W-1:0] share_a;
        logic [WEIGHT_W-1:0] share_b;
        logic [WEIGHT_W-1:0] share_c;
        logic [WEIGHT_W-1:0] share_d;
    } t_result;

    typedef struct packed {
        logic [JOINT_W-1:0]  joint;
        logic [WEIGHT_W-1:0] weight;
    } t_slot;

endpackage

// ----- hw/rtl/vertex_influence_packer_core.sv -----
// Per-vertex skinning influence table: one memory row per vertex holds all of its
// (joint, weight) slots. After reset the block clears the table, one row per cycle,
// and holds busy high until the last row is written. An add request then passes from
// acceptance to the next possible acceptance through row read, slot update and
// write-back, and a result cycle. A read request of a vertex with nonzero total waits
// on the four normalized shares, which come from four restoring dividers working side
// by side at one quotient bit per cycle; a read of an empty or out-of-range vertex
// takes the add path's steps. Each result is shown for a single cycle with o_strobe
// and cannot be held off, so the receiver must take it in that cycle.
module vertex_influence_packer_core
    import vip_pkg::*;
#(
    parameter int MAX_VERTICES     = DEF_MAX_VERTICES,
    parameter int SLOTS_PER_VERTEX = DEF_SLOTS_PER_VERTEX
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_request i_request,
    output logic     o_strobe,
    output t_result  o_result
);

    localparam int S      = SLOTS_PER_VERTEX;
    localparam int SLOT_W = $bits(t_slot);
    localparam int ROW_W  = S * SLOT_W;
    localparam int PS     = (S > SHOWN_SLOTS) ? S : SHOWN_SLOTS;
    localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TW     = $clog2(S * 65536 + 1);

    t_state   r_state;
    t_state   n_state;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] n_clr;
    t_request r_req;
    t_request n_req;
    logic     r_strobe;
    logic     n_strobe;
    t_result  r_result;
    t_result  n_result;
    logic [SHOWN_SLOTS-1:0][JOINT_W-1:0] r_joints;
    logic [SHOWN_SLOTS-1:0][JOINT_W-1:0] n_joints;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_data;
    logic [ROW_W-1:0] rd_data;
    logic [AW-1:0]    vaddr;
    logic [31:0]      vtx_ext;
    logic             vtx_ok;
    logic             joint_ok;

    t_slot [S-1:0]    row;
    t_slot [S-1:0]    row_mod;
    t_slot [PS-1:0]   row_pad;
    logic             found;
    logic [WEIGHT_W-1:0] wsat;
    logic [TW-1:0]    total;

    logic                                div_start;
    logic [SHOWN_SLOTS-1:0]              div_busy;
    logic [SHOWN_SLOTS-1:0][NUM_W-1:0]   num;
    logic [SHOWN_SLOTS-1:0][QUOT_W-1:0]  quot;

    assign vtx_ext  = 32'(r_req.vertex_index);
    assign vaddr    = vtx_ext[AW-1:0];
    assign vtx_ok   = (vtx_ext < 32'(MAX_VERTICES));
    assign joint_ok = (32'(r_req.joint_index) < 32'(MAX_JOINTS));
    assign wsat     = (r_req.weight > ONE_Q16) ? ONE_Q16 : r_req.weight;

    vip_store #(
        .DEPTH  (MAX_VERTICES),
        .ROW_W  (ROW_W),
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (vaddr),
        .o_rd_data (rd_data)
    );

    // row view, first empty slot update, total over all slots, and divider numerators
    always_comb begin
        row     = rd_data;
        row_pad = (PS * SLOT_W)'(rd_data);
        row_mod = row;
        found   = 1'b0;
        total   = '0;
        for (int k = 0; k < S; k++) begin
            total = total + TW'(row[k].weight);
            if (!found && row[k].weight == '0) begin
                row_mod[k].joint  = r_req.joint_index;
                row_mod[k].weight = wsat;
                found = 1'b1;
            end
        end
        for (int k = 0; k < SHOWN_SLOTS; k++) begin
            num[k] = {row_pad[k].weight, FRAC_W'(0)} + NUM_W'(total >> 1);
        end
    end

    for (genvar g = 0; g < SHOWN_SLOTS; g++) begin : g_lane
        vip_div #(
            .DEN_W (TW)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (num[g]),
            .i_den   (total),
            .o_busy  (div_busy[g]),
            .o_quot  (quot[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_req     = r_req;
        n_strobe  = 1'b0;
        n_result  = r_result;
        n_joints  = r_joints;
        wr_en     = 1'b0;
        wr_addr   = vaddr;
        wr_data   = ROW_W'(row_mod);
        div_start = 1'b0;
        case (r_state)
            STATE_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(MAX_VERTICES - 1)) begin
                    n_state = STATE_IDLE;
                end
            end
            STATE_IDLE: begin
                if (start) begin
                    n_req   = i_request;
                    n_state = STATE_FETCH;
                end
            end
            STATE_FETCH: begin
                n_state = STATE_EVAL;
            end
            STATE_EVAL: begin
                for (int k = 0; k < SHOWN_SLOTS; k++) begin
                    n_joints[k] = row_pad[k].joint;
                end
                if (r_req.operation == OP_ADD) begin
                    n_result = '0;
                    n_strobe = 1'b1;
                    n_state  = STATE_IDLE;
                    if (vtx_ok && joint_ok && found) begin
                        wr_en           = 1'b1;
                        n_result.status = STATUS_STORED;
                    end else begin
                        n_result.status = STATUS_DROPPED;
                    end
                end else if (!vtx_ok || total == '0) begin
                    // empty or out-of-range vertex reads as joint 0 with full weight
                    n_result         = '0;
                    n_result.status  = STATUS_READ;
                    n_result.share_a = ONE_Q16;
                    if (vtx_ok) begin
                        n_result.joint_b = row_pad[1].joint;
                        n_result.joint_c = row_pad[2].joint;
                        n_result.joint_d = row_pad[3].joint;
                    end
                    n_strobe = 1'b1;
                    n_state  = STATE_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = STATE_DIVIDE;
                end
            end
            STATE_DIVIDE: begin
                if (!(|div_busy)) begin
                    n_result.status  = STATUS_READ;
                    n_result.joint_a = r_joints[0];
                    n_result.joint_b = r_joints[1];
                    n_result.joint_c = r_joints[2];
                    n_result.joint_d = r_joints[3];
                    n_result.share_a = quot[0];
                    n_result.share_b = quot[1];
                    n_result.share_c = quot[2];
                    n_result.share_d = quot[3];
                    n_strobe = 1'b1;
                    n_state  = STATE_IDLE;
                end
            end
            default: begin
                n_state = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= STATE_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_result <= n_result;
        r_joints <= n_joints;
    end

    assign busy     = (r_state != STATE_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_add_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_request.operation == OP_ADD) |-> ##3
        (o_strobe && (o_result.status == STATUS_STORED
                      || o_result.status == STATUS_DROPPED)))
        else $error("add request did not report in three cycles");

    a_status_matches_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_result.status == STATUS_READ) == (r_req.operation == OP_READ)))
        else $error("result status does not match request operation");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_strobe))
        else $error("block not busy clearing after reset");

endmodule

// ----- hw/rtl/vip_store.sv -----
module vip_store
    import vip_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_VERTICES,
    parameter int ROW_W  = DEF_SLOTS_PER_VERTEX * $bits(t_slot),
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [ROW_W-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [ROW_W-1:0]  o_rd_data
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/vip_div.sv -----
module vip_div
    import vip_pkg::*;
#(
    parameter int DEN_W = WEIGHT_W + 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_busy,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  n_rem;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] n_low;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // restoring division, one quotient bit per cycle; the low word shifts
    // the numerator out and the quotient in
    always_comb begin
        trial = {r_rem, r_low[QUOT_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_low = r_low;
        if (i_start) begin
            n_cnt = CNT_W'(QUOT_W);
            n_rem = DEN_W'(i_num[NUM_W-1:QUOT_W]);
            n_low = i_num[QUOT_W-1:0];
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_low = {r_low[QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_low;

endmodule
